FILE: rtl/core/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = 16;
	localparam int DIV_STEPS = GAIN_BITS;

	localparam logic [16:0] GAIN_ONE = 17'h10000;

	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
	localparam logic [31:0] RESET_Q = 32'((ONE_Q + 64'd50) / 64'd100);
	localparam logic [31:0] RESET_R = 32'((64'd7 * ONE_Q + 64'd50) / 64'd100);
	localparam logic [31:0] RESET_X = 32'(64'd50 * ONE_Q);
	localparam logic [31:0] RESET_P = 32'(64'd10 * ONE_Q);

	localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [1:0] REG_MEASURE_NOISE = 2'd1;
	localparam logic [1:0] REG_INIT_ESTIMATE = 2'd2;
	localparam logic [1:0] REG_INIT_COVARIANCE = 2'd3;

	localparam logic MODE_FILTER = 1'b0;
	localparam logic MODE_RELOAD = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] estimate;
		logic [16:0] gain;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic div_step;
		logic mul_x;
		logic mul_p;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic reload;
		logic zero_r;
	} status_t;

endpackage

FILE: rtl/core/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter.
// Each transfer on the input channel yields one result transfer. A filter sample
// is committed before the next sample can be taken; it passes through the
// 16-step restoring divider that forms the gain, followed by two passes through one
// shared 32x17 multiplier; with measure_noise at zero the divider is skipped, and a
// reload skips both. A finished result sits in an output
// register, so the next sample is taken while it waits; the block stalls only when a
// second result is ready before the first has been transferred. Configuration writes
// take effect at once, so they should be made only while no sample is in flight.
module scalar_kalman_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  skf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output skf_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);

	skf_pkg::cmd_t    cmd;
	skf_pkg::status_t status;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	skf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/core/skf_datapath.sv
// Datapath of the scalar Kalman filter: state, registers, divider and shared multiplier.
module skf_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  skf_pkg::cmd_t      cmd,
	output skf_pkg::status_t   status,
	input  skf_pkg::in_item_t  in_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	output skf_pkg::out_item_t out_data
);

	logic [31:0] q_q, r_q, init_x_q, init_p_q;
	logic [31:0] est_q, cov_q;
	logic        mode_q;
	logic [31:0] sample_q;
	logic [31:0] pmid_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [16:0] quot_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic [48:0] prod_q;
	logic [31:0] xnew_q;
	skf_pkg::out_item_t out_q;

	logic [32:0] psum;
	logic [31:0] pmid;
	logic        neg;
	logic [33:0] trial;
	logic        fits;
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] prod;
	logic [31:0] step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= skf_pkg::RESET_Q;
			r_q <= skf_pkg::RESET_R;
			init_x_q <= skf_pkg::RESET_X;
			init_p_q <= skf_pkg::RESET_P;
		end else if (cfg_we) begin
			case (cfg_index)
				skf_pkg::REG_PROCESS_NOISE: q_q <= cfg_wdata;
				skf_pkg::REG_MEASURE_NOISE: r_q <= cfg_wdata;
				skf_pkg::REG_INIT_ESTIMATE: init_x_q <= cfg_wdata;
				skf_pkg::REG_INIT_COVARIANCE: init_p_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign psum = {1'b0, cov_q} + {1'b0, q_q};
	assign pmid = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
	assign neg = sample_q < est_q;

	assign trial = {rem_q[32:0], 1'b0};
	assign fits = trial >= {1'b0, den_q};

	assign mul_a = cmd.mul_x ? mag_q : pmid_q;
	assign mul_b = cmd.mul_x ? quot_q : (skf_pkg::GAIN_ONE - quot_q);
	assign prod = {17'b0, mul_a} * {32'b0, mul_b};
	assign step = prod_q[47:16];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_data.mode;
			sample_q <= in_data.sample;
		end
		if (cmd.load) begin
			pmid_q <= pmid;
			den_q <= {1'b0, pmid} + {1'b0, r_q};
			rem_q <= {2'b0, pmid};
			if (r_q == 32'd0) begin
				quot_q <= (pmid != 32'd0) ? skf_pkg::GAIN_ONE : 17'd0;
			end else begin
				quot_q <= 17'd0;
			end
			neg_q <= neg;
			mag_q <= neg ? (est_q - sample_q) : (sample_q - est_q);
		end
		if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[15:0], fits};
		end
		if (cmd.mul_x || cmd.mul_p) begin
			prod_q <= prod;
		end
		if (cmd.mul_p) begin
			xnew_q <= neg_q ? (est_q - step) : (est_q + step);
		end
		if (cmd.commit) begin
			if (mode_q == skf_pkg::MODE_RELOAD) begin
				out_q.estimate <= init_x_q;
				out_q.gain <= 17'd0;
			end else begin
				out_q.estimate <= xnew_q;
				out_q.gain <= quot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= skf_pkg::RESET_X;
			cov_q <= skf_pkg::RESET_P;
		end else if (cmd.commit) begin
			if (mode_q == skf_pkg::MODE_RELOAD) begin
				est_q <= init_x_q;
				cov_q <= init_p_q;
			end else begin
				est_q <= xnew_q;
				cov_q <= step;
			end
		end
	end

	assign status.reload = (mode_q == skf_pkg::MODE_RELOAD);
	assign status.zero_r = (r_q == 32'd0);
	assign out_data = out_q;

endmodule

FILE: rtl/core/skf_ctrl.sv
// Sequencing controller of the scalar Kalman filter.
module skf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  skf_pkg::status_t status,
	output skf_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_MULX = 3'd3;
	localparam logic [2:0] S_MULP = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	localparam logic [3:0] LAST_STEP = 4'(skf_pkg::DIV_STEPS - 1);

	logic [2:0] state_q, state_d;
	logic [3:0] count_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = !status.reload;
				if (status.reload) begin
					state_d = S_FIN;
				end else if (status.zero_r) begin
					state_d = S_MULX;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (count_q == LAST_STEP) begin
					state_d = S_MULX;
				end
			end
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d = S_MULP;
			end
			S_MULP: begin
				cmd.mul_p = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				count_q <= count_q + 4'd1;
			end else begin
				count_q <= 4'd0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/skf_checker.sv
// Port checker for the scalar Kalman filter and its bind to the top level.
module skf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input skf_pkg::out_item_t out_data
);

	// A held result keeps its value until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed before its transfer");

	// After an input transfer the block is busy with that sample.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	// A new result appears only at the end of a sample, never out of idle.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a sample in flight");

	// The gain never exceeds one.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.gain <= skf_pkg::GAIN_ONE)
		else $error("gain above one");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
